// ===== design/fnu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnu_pkg
// Shared widths, types and helpers of the face normal unit.
// ----------------------------------------------------------------------------
package fnu_pkg;

    localparam int COORD_BITS        = 16;
    localparam int MAX_FACE_VERTICES = 16;

    localparam int DIFF_W     = 17;
    localparam int DIFF_SHIFT = (COORD_BITS > 16) ? (COORD_BITS - 16) : 0;
    localparam int CROSS_W    = 35;
    localparam int MAG_W      = 34;
    localparam int MAG_LO_W   = 18;
    localparam int MAG_HI_W   = MAG_W - MAG_LO_W;
    localparam int WIDE_W     = 70;
    localparam int QUO_W      = 31;
    localparam int ROOT_W     = 16;
    localparam int NORM_W     = 16;
    localparam int MUL_W      = 19;
    localparam int PROD_W     = 2 * MUL_W;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int CFG_W     = 5;
    localparam int CNT_W     = 5;
    localparam int VNUM_W    = 4;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int VPF_MIN   = 3;
    localparam int CNT_LIMIT = (MAX_FACE_VERTICES < 16) ? MAX_FACE_VERTICES : 16;

    localparam logic [CFG_W-1:0] VPF_RESET = CFG_W'(3);
    localparam logic [0:0]       REG_VPF   = 1'b0;

    typedef struct packed {
        logic signed [DIFF_W-1:0] abx;
        logic signed [DIFF_W-1:0] aby;
        logic signed [DIFF_W-1:0] abz;
        logic signed [DIFF_W-1:0] bcx;
        logic signed [DIFF_W-1:0] bcy;
        logic signed [DIFF_W-1:0] bcz;
    } fnu_diff_t;

    // to - from, floored down to 17 bits for wide coordinates
    function automatic logic signed [DIFF_W-1:0] coord_diff(
        input logic [COORD_BITS-1:0] to_c,
        input logic [COORD_BITS-1:0] from_c
    );
        logic signed [COORD_BITS:0] d;
        d = $signed({to_c[COORD_BITS-1], to_c}) - $signed({from_c[COORD_BITS-1], from_c});
        return DIFF_W'(d >>> DIFF_SHIFT);
    endfunction

    function automatic logic [CNT_W-1:0] face_count(input logic [CFG_W-1:0] vpf);
        logic [CNT_W-1:0] c;
        c = CNT_W'(vpf);
        if (c < CNT_W'(VPF_MIN))
            c = CNT_W'(VPF_MIN);
        if (c > CNT_W'(CNT_LIMIT))
            c = CNT_W'(CNT_LIMIT);
        return c;
    endfunction

endpackage

// ===== design/fnu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnu_front
// Accepts face requests and forms the edge vectors AB and BC.
// ----------------------------------------------------------------------------
module fnu_front
    import fnu_pkg::*;
(
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] ax,
    input  logic [COORD_BITS-1:0] ay,
    input  logic [COORD_BITS-1:0] az,
    input  logic [COORD_BITS-1:0] bx,
    input  logic [COORD_BITS-1:0] by_coord,
    input  logic [COORD_BITS-1:0] bz,
    input  logic [COORD_BITS-1:0] cx,
    input  logic [COORD_BITS-1:0] cy,
    input  logic [COORD_BITS-1:0] cz,
    input  logic                  queue_full,
    output logic                  push,
    output fnu_diff_t             push_data
);

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        push_data.abx = coord_diff(bx, ax);
        push_data.aby = coord_diff(by_coord, ay);
        push_data.abz = coord_diff(bz, az);
        push_data.bcx = coord_diff(cx, bx);
        push_data.bcy = coord_diff(cy, by_coord);
        push_data.bcz = coord_diff(cz, bz);
    end

endmodule

// ===== design/fnu_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnu_fifo
// Short queue of edge vectors between the front and the back.
// ----------------------------------------------------------------------------
module fnu_fifo
    import fnu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  fnu_diff_t push_data,
    output logic      full,
    input  logic      pop,
    output logic      valid,
    output fnu_diff_t pop_data
);

    fnu_diff_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== design/fnu_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnu_back
// Cross product, length, per-component divide and square root, and the
// per-vertex copies of the normal; cross product, squares and root trials share one multiplier.
// ----------------------------------------------------------------------------
module fnu_back
    import fnu_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     queue_valid,
    input  fnu_diff_t                queue_data,
    output logic                     queue_pop,
    input  logic [CFG_W-1:0]         vertices_per_face,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [NORM_W-1:0] nx,
    output logic signed [NORM_W-1:0] ny,
    output logic signed [NORM_W-1:0] nz,
    output logic                     degenerate,
    output logic [VNUM_W-1:0]        vertex_number,
    output logic                     last
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CROSS = 3'd1;
    localparam logic [2:0] ST_SQ    = 3'd2;
    localparam logic [2:0] ST_CHK   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_SQRT  = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    localparam logic [4:0] CROSS_LAST = 5'd5;
    localparam logic [4:0] SQ_LAST    = 5'd2;
    localparam logic [1:0] COMP_LAST  = 2'd2;

    logic [2:0]                 state_reg, state_next;
    logic [4:0]                 step_reg, step_next;
    logic [1:0]                 comp_reg, comp_next;
    fnu_diff_t                  d_reg, d_next;
    logic signed [CROSS_W-1:0]  c_reg [3];
    logic signed [CROSS_W-1:0]  c_next [3];
    logic [WIDE_W-1:0]          c2_reg [3];
    logic [WIDE_W-1:0]          c2_next [3];
    logic [WIDE_W-1:0]          s_reg, s_next;
    logic [WIDE_W-1:0]          rem_reg, rem_next;
    logic [QUO_W-1:0]           q_reg, q_next;
    logic [ROOT_W-1:0]          root_reg, root_next;
    logic signed [NORM_W-1:0]   n_reg [3];
    logic signed [NORM_W-1:0]   n_next [3];
    logic                       deg_reg, deg_next;
    logic [VNUM_W-1:0]          k_reg, k_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [NORM_W-1:0]   nx_reg, nx_next, ny_reg, ny_next, nz_reg, nz_next;
    logic                       odeg_reg, odeg_next;
    logic [VNUM_W-1:0]          vnum_reg, vnum_next;
    logic                       last_reg, last_next;

    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic signed [PROD_W-1:0]   prod;
    logic [MAG_W-1:0]           mag_cur;
    logic [MAG_HI_W-1:0]        mag_hi;
    logic [MAG_LO_W-1:0]        mag_lo;
    logic [ROOT_W-1:0]          trial_root;
    logic [WIDE_W:0]            trial_rem;
    logic                       rem_ge;
    logic [WIDE_W-1:0]          sq_term, sq_acc;
    logic                       root_fits;
    logic [ROOT_W-1:0]          root_fin;
    logic [ROOT_W:0]            root_inc;
    logic [NORM_W-1:0]          r_mag;
    logic [CNT_W-1:0]           count;
    logic                       k_last;

    assign count  = face_count(vertices_per_face);
    assign k_last = ((CNT_W'(k_reg) + 1'b1) == count);

    assign mag_cur = c_reg[comp_reg][CROSS_W-1] ? MAG_W'(-c_reg[comp_reg])
                                                : MAG_W'(c_reg[comp_reg]);
    assign mag_hi  = mag_cur[MAG_W-1:MAG_LO_W];
    assign mag_lo  = mag_cur[MAG_LO_W-1:0];

    assign trial_root = root_reg | (ROOT_W'(1) << step_reg[3:0]);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_CROSS:
            begin
                unique case (step_reg[2:0])
                    3'd0:    begin mul_a = MUL_W'(d_reg.aby); mul_b = MUL_W'(d_reg.bcz); end
                    3'd1:    begin mul_a = MUL_W'(d_reg.abz); mul_b = MUL_W'(d_reg.bcy); end
                    3'd2:    begin mul_a = MUL_W'(d_reg.abz); mul_b = MUL_W'(d_reg.bcx); end
                    3'd3:    begin mul_a = MUL_W'(d_reg.abx); mul_b = MUL_W'(d_reg.bcz); end
                    3'd4:    begin mul_a = MUL_W'(d_reg.abx); mul_b = MUL_W'(d_reg.bcy); end
                    default: begin mul_a = MUL_W'(d_reg.aby); mul_b = MUL_W'(d_reg.bcx); end
                endcase
            end
            ST_SQ:
            begin
                unique case (step_reg[1:0])
                    2'd0:    begin mul_a = MUL_W'(mag_hi); mul_b = MUL_W'(mag_hi); end
                    2'd1:    begin mul_a = MUL_W'(mag_hi); mul_b = MUL_W'(mag_lo); end
                    default: begin mul_a = MUL_W'(mag_lo); mul_b = MUL_W'(mag_lo); end
                endcase
            end
            ST_SQRT:
            begin
                mul_a = MUL_W'(trial_root);
                mul_b = MUL_W'(trial_root);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // square of |c| from three partial products: hi*hi, 2*hi*lo, lo*lo
    always_comb
    begin
        unique case (step_reg[1:0])
            2'd0:    sq_term = WIDE_W'(prod[PROD_W-2:0]) << (2 * MAG_LO_W);
            2'd1:    sq_term = WIDE_W'(prod[PROD_W-2:0]) << (MAG_LO_W + 1);
            default: sq_term = WIDE_W'(prod[PROD_W-2:0]);
        endcase
        sq_acc = ((step_reg == '0) ? '0 : c2_reg[comp_reg]) + sq_term;
    end

    // restoring divide of c^2 * 2^30 by |N|^2, one quotient bit a cycle
    assign trial_rem = (step_reg == 5'(QUO_W - 1)) ? {1'b0, c2_reg[comp_reg]}
                                                   : {rem_reg, 1'b0};
    assign rem_ge    = (trial_rem >= {1'b0, s_reg});

    // integer square root of the quotient, one root bit a cycle
    assign root_fits = ($unsigned(prod) <= PROD_W'(q_reg));
    assign root_fin  = root_fits ? trial_root : root_reg;
    assign root_inc  = {1'b0, root_fin} + 1'b1;
    assign r_mag     = NORM_W'(root_inc >> 1);

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        comp_next      = comp_reg;
        d_next         = d_reg;
        c_next         = c_reg;
        c2_next        = c2_reg;
        s_next         = s_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        root_next      = root_reg;
        n_next         = n_reg;
        deg_next       = deg_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        nz_next        = nz_reg;
        odeg_next      = odeg_reg;
        vnum_next      = vnum_reg;
        last_next      = last_reg;
        queue_pop      = 1'b0;

        if (out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (queue_valid)
                begin
                    d_next     = queue_data;
                    queue_pop  = 1'b1;
                    step_next  = '0;
                    state_next = ST_CROSS;
                end
            end
            ST_CROSS:
            begin
                if (!step_reg[0])
                    c_next[step_reg[2:1]] = CROSS_W'(prod);
                else
                    c_next[step_reg[2:1]] = c_reg[step_reg[2:1]] - CROSS_W'(prod);
                if (step_reg == CROSS_LAST)
                begin
                    step_next  = '0;
                    comp_next  = '0;
                    s_next     = '0;
                    state_next = ST_SQ;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            ST_SQ:
            begin
                c2_next[comp_reg] = sq_acc;
                if (step_reg == SQ_LAST)
                begin
                    s_next    = s_reg + sq_acc;
                    step_next = '0;
                    if (comp_reg == COMP_LAST)
                        state_next = ST_CHK;
                    else
                        comp_next = comp_reg + 1'b1;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            ST_CHK:
            begin
                k_next = '0;
                if (s_reg == '0)
                begin
                    // zero cross product: zero normal
                    deg_next   = 1'b1;
                    n_next[0]  = '0;
                    n_next[1]  = '0;
                    n_next[2]  = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    deg_next   = 1'b0;
                    comp_next  = '0;
                    step_next  = 5'(QUO_W - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = rem_ge ? WIDE_W'(trial_rem - {1'b0, s_reg}) : WIDE_W'(trial_rem);
                q_next   = {q_reg[QUO_W-2:0], rem_ge};
                if (step_reg == '0)
                begin
                    root_next  = '0;
                    step_next  = 5'(ROOT_W - 1);
                    state_next = ST_SQRT;
                end
                else
                    step_next = step_reg - 1'b1;
            end
            ST_SQRT:
            begin
                root_next = root_fin;
                if (step_reg == '0)
                begin
                    // round half up: (root + 1) / 2, then restore the sign
                    n_next[comp_reg] = c_reg[comp_reg][CROSS_W-1] ? -$signed(r_mag)
                                                                  : $signed(r_mag);
                    if (comp_reg == COMP_LAST)
                        state_next = ST_EMIT;
                    else
                    begin
                        comp_next  = comp_reg + 1'b1;
                        step_next  = 5'(QUO_W - 1);
                        state_next = ST_DIV;
                    end
                end
                else
                    step_next = step_reg - 1'b1;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    nx_next        = n_reg[0];
                    ny_next        = n_reg[1];
                    nz_next        = n_reg[2];
                    odeg_next      = deg_reg;
                    vnum_next      = k_reg;
                    last_next      = k_last;
                    k_next         = k_reg + 1'b1;
                    if (k_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        comp_reg <= comp_next;
        d_reg    <= d_next;
        c_reg    <= c_next;
        c2_reg   <= c2_next;
        s_reg    <= s_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        root_reg <= root_next;
        n_reg    <= n_next;
        deg_reg  <= deg_next;
        k_reg    <= k_next;
        nx_reg   <= nx_next;
        ny_reg   <= ny_next;
        nz_reg   <= nz_next;
        odeg_reg <= odeg_next;
        vnum_reg <= vnum_next;
        last_reg <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign nx            = nx_reg;
    assign ny            = ny_reg;
    assign nz            = nz_reg;
    assign degenerate    = odeg_reg;
    assign vertex_number = vnum_reg;
    assign last          = last_reg;

endmodule

// ===== design/face_normal_unit_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// face_normal_unit_core
// Unit face normal from three vertices, emitted once per face vertex.
// ----------------------------------------------------------------------------
// Each request carries vertices A, B, C (Q8.8). The front forms AB and BC and
// queues them in a two-entry queue, so requests are taken every cycle until
// the queue fills. The back works one face at a time on a single 19x19
// multiplier: it pops the queue, forms the cross product, squares the three
// components, checks the length, then per component runs a restoring divide
// and a square root, and emits one copy per face vertex (a degenerate face
// skips the divide and root), waiting while the receiver stalls. The result
// is Q1.14, rounded to nearest, emitted vertices_per_face times (clamped to
// 3..16) from a registered output.
// ----------------------------------------------------------------------------
module face_normal_unit_core
    import fnu_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [COORD_BITS-1:0]    ax,
    input  logic [COORD_BITS-1:0]    ay,
    input  logic [COORD_BITS-1:0]    az,
    input  logic [COORD_BITS-1:0]    bx,
    input  logic [COORD_BITS-1:0]    by_coord,
    input  logic [COORD_BITS-1:0]    bz,
    input  logic [COORD_BITS-1:0]    cx,
    input  logic [COORD_BITS-1:0]    cy,
    input  logic [COORD_BITS-1:0]    cz,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [NORM_W-1:0] nx,
    output logic signed [NORM_W-1:0] ny,
    output logic signed [NORM_W-1:0] nz,
    output logic                     degenerate,
    output logic [VNUM_W-1:0]        vertex_number,
    output logic                     last
);

    logic [CFG_W-1:0] vpf_reg, vpf_next;
    logic             q_full, q_push, q_pop, q_valid;
    fnu_diff_t        q_wdata, q_rdata;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1] == REG_VPF);
    assign prdata  = reg_sel ? PDATA_W'(vpf_reg) : '0;

    always_comb
    begin
        vpf_next = vpf_reg;
        if (psel && penable && pwrite && reg_sel)
            vpf_next = pwdata[CFG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vpf_reg <= VPF_RESET;
        else
            vpf_reg <= vpf_next;
    end

    fnu_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ax         (ax),
        .ay         (ay),
        .az         (az),
        .bx         (bx),
        .by_coord   (by_coord),
        .bz         (bz),
        .cx         (cx),
        .cy         (cy),
        .cz         (cz),
        .queue_full (q_full),
        .push       (q_push),
        .push_data  (q_wdata)
    );

    fnu_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_rdata)
    );

    fnu_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .queue_valid       (q_valid),
        .queue_data        (q_rdata),
        .queue_pop         (q_pop),
        .vertices_per_face (vpf_reg),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .nx                (nx),
        .ny                (ny),
        .nz                (nz),
        .degenerate        (degenerate),
        .vertex_number     (vertex_number),
        .last              (last)
    );

endmodule
